/* src/normalized_hash_dedup_set_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the normalized hash dedup set core
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef NORMALIZED_HASH_DEDUP_SET_CORE_DEFINES_SVH
`define NORMALIZED_HASH_DEDUP_SET_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define NHDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define NHDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define NHDS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NHDS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* src/nhds_pkg.sv */
// ----------------------------------------------------------------------------
// nhds_pkg
// Shared types, constants and hash helpers of the normalized hash dedup set.
// ----------------------------------------------------------------------------
`default_nettype none

package nhds_pkg;

   localparam int HASH_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int TOTAL_W    = 11;
   localparam int TREE_FANIN = 32;

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

   localparam logic [BYTE_W-1:0] NUL_CHAR    = 8'h00;
   localparam logic [BYTE_W-1:0] SPACE_CHAR  = 8'h20;
   localparam logic [BYTE_W-1:0] UPPER_A     = 8'h41;
   localparam logic [BYTE_W-1:0] UPPER_Z     = 8'h5a;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MIX,
      S_CMP,
      S_WAIT,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic cmp_en;
      logic shift_en;
   } cell_ctrl_type;

   // One FNV-1a step. The prime is 2^40 + 0x1b3, so the product is formed
   // from a handful of shifted copies instead of a full multiplier.
   function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      begin
         x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
         fnv_mix = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                   + (x << 1) + x;
      end
   endfunction

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
      begin
         if (c inside {[UPPER_A:UPPER_Z]}) begin
            fold_case = c + CASE_OFFSET;
         end else begin
            fold_case = c;
         end
      end
   endfunction

endpackage

`default_nettype wire

/* src/nhds_cell.sv */
// ----------------------------------------------------------------------------
// nhds_cell
// One slot of the sorted hash chain: compare against the key, then keep,
// take the key, or take the left neighbor's entry on an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module nhds_cell
   import nhds_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [HASH_W-1:0]   key,
   input  wire logic                occupied,
   input  wire logic                prev_lt,
   input  wire logic [HASH_W-1:0]   prev_entry,
   output logic                     lt,
   output logic                     eq,
   output logic [HASH_W-1:0]        entry
);

   logic              lt_ff;
   logic              eq_ff;
   logic [HASH_W-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lt_ff <= 1'b0;
         eq_ff <= 1'b0;
      end else if (ctrl.cmp_en) begin
         lt_ff <= occupied && (entry_ff < key);
         eq_ff <= occupied && (entry_ff == key);
      end
   end

   // Cells below the insertion point keep their entry; the cell at the
   // insertion point takes the key and every cell above it shifts up by one.
   always_ff @(posedge clock) begin
      if (ctrl.shift_en && !lt_ff) begin
         entry_ff <= prev_lt ? key : prev_entry;
      end
   end

   assign lt    = lt_ff;
   assign eq    = eq_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

/* src/nhds_or_stage.sv */
// ----------------------------------------------------------------------------
// nhds_or_stage
// One registered level of the match-reduction tree.
// ----------------------------------------------------------------------------
`default_nettype none

module nhds_or_stage
   import nhds_pkg::*;
#(
   parameter  int IN_W  = 32,
   localparam int OUT_W = (IN_W + TREE_FANIN - 1) / TREE_FANIN
) (
   input  wire logic             clock,
   input  wire logic [IN_W-1:0]  bits,
   output logic      [OUT_W-1:0] ored
);

   logic [OUT_W-1:0] ored_ff;
   logic [OUT_W-1:0] ored_in;

   for (genvar g = 0; g < OUT_W; g++) begin : g_grp
      localparam int LO = g * TREE_FANIN;
      localparam int HI = ((LO + TREE_FANIN) < IN_W) ? (LO + TREE_FANIN - 1) : (IN_W - 1);
      assign ored_in[g] = |bits[HI:LO];
   end

   always_ff @(posedge clock) begin
      ored_ff <= ored_in;
   end

   assign ored = ored_ff;

endmodule

`default_nettype wire

/* src/normalized_hash_dedup_set_core.sv */
// ----------------------------------------------------------------------------
// normalized_hash_dedup_set_core
// Normalized FNV-1a 64-bit message hash with a bounded sorted dedup set.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                  Handshake
//   -------   ------------------------------------   ----------------------------
//   request   req_text_byte, req_last_byte           start high while busy low
//   response  rsp_is_duplicate .. rsp_message_hash   rsp_strobe, one cycle only
//
// A byte that is not the last is taken while idle; one that closes a
// whitespace run is mixed in two steps, the pending space first and then
// the byte in S_MIX, with the byte held in a register between the steps.
// A last byte then passes S_CMP, in which every cell compares its entry
// with the hash, S_WAIT, through the four registered levels of the
// match-OR tree, and S_DECIDE, in which the cells shift and the count is
// updated. The strobe appears in the cycle after that; busy is already low.
// Reset clears the per-message state, the entry count and the control; the
// table entries themselves are not cleared, since only entries below the
// count are ever compared. The receiver cannot stall, so the response
// register is simply overwritten by the next completed message.
// ----------------------------------------------------------------------------
`default_nettype none

`include "normalized_hash_dedup_set_core_defines.svh"

module normalized_hash_dedup_set_core
   import nhds_pkg::*;
#(
   parameter int TABLE_CAPACITY = 1024
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [BYTE_W-1:0]   req_text_byte,
   input  wire logic                req_last_byte,
   output logic                     rsp_strobe,
   output logic                     rsp_is_duplicate,
   output logic                     rsp_was_inserted,
   output logic                     rsp_set_full,
   output logic [TOTAL_W-1:0]       rsp_entry_total,
   output logic [HASH_W-1:0]        rsp_message_hash
);

   localparam int COUNT_W = $clog2(TABLE_CAPACITY + 1);
   localparam int L1_W    = (TABLE_CAPACITY + TREE_FANIN - 1) / TREE_FANIN;
   localparam int L2_W    = (L1_W + TREE_FANIN - 1) / TREE_FANIN;
   localparam int L3_W    = (L2_W + TREE_FANIN - 1) / TREE_FANIN;
   localparam int L4_W    = (L3_W + TREE_FANIN - 1) / TREE_FANIN;
   localparam int WAIT_W  = 2;
   localparam logic [WAIT_W-1:0] WAIT_LAST = '1;

   // Control and per-message state.
   state_type           state_ff, state_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic                seen_ff, seen_in;
   logic                gap_ff, gap_in;
   logic                stopped_ff, stopped_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;
   logic [WAIT_W-1:0]   wait_ff, wait_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   // Response registers.
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_dup_ff, rsp_dup_in;
   logic                rsp_ins_ff, rsp_ins_in;
   logic                rsp_full_ff, rsp_full_in;
   logic [TOTAL_W-1:0]  rsp_total_ff, rsp_total_in;
   logic [HASH_W-1:0]   rsp_hash_ff, rsp_hash_in;

   // Cell chain.
   cell_ctrl_type             cell_ctrl;
   logic [TABLE_CAPACITY-1:0] cell_lt;
   logic [TABLE_CAPACITY-1:0] cell_eq;
   logic [TABLE_CAPACITY-1:0] cell_occ;
   logic [HASH_W-1:0]         cell_entry [TABLE_CAPACITY];

   // Match-reduction tree.
   logic [L1_W-1:0] tree_l1;
   logic [L2_W-1:0] tree_l2;
   logic [L3_W-1:0] tree_l3;
   logic [L4_W-1:0] tree_l4;

   logic                table_full;
   logic                hit;
   logic                do_insert;
   logic [31:0]         count_wide;
   logic [BYTE_W-1:0]   folded;
   logic [2:0]          rsp_flags;

   // ------------------------------------------------------------------------
   // The chain: cell i compares its entry with the finished hash, and on an
   // insert takes either the hash or cell i-1's entry. Cell 0 sees "all
   // cells to my left are smaller", so it takes the hash when it is not
   // itself smaller.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < TABLE_CAPACITY; i++) begin : g_cell
      assign cell_occ[i] = COUNT_W'(i) < count_ff;

      if (i == 0) begin : g_head
         nhds_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .key        (hash_ff),
            .occupied   (cell_occ[i]),
            .prev_lt    (1'b1),
            .prev_entry (hash_ff),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i]),
            .entry      (cell_entry[i])
         );
      end else begin : g_body
         nhds_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (cell_ctrl),
            .key        (hash_ff),
            .occupied   (cell_occ[i]),
            .prev_lt    (cell_lt[i-1]),
            .prev_entry (cell_entry[i-1]),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i]),
            .entry      (cell_entry[i])
         );
      end
   end

   // At most one cell can match, since the table holds distinct hashes; the
   // tree gathers that single flag in four registered levels.
   nhds_or_stage #(.IN_W(TABLE_CAPACITY)) u_or_l1 (.clock(clock), .bits(cell_eq), .ored(tree_l1));
   nhds_or_stage #(.IN_W(L1_W))           u_or_l2 (.clock(clock), .bits(tree_l1), .ored(tree_l2));
   nhds_or_stage #(.IN_W(L2_W))           u_or_l3 (.clock(clock), .bits(tree_l2), .ored(tree_l3));
   nhds_or_stage #(.IN_W(L3_W))           u_or_l4 (.clock(clock), .bits(tree_l3), .ored(tree_l4));

   assign hit        = tree_l4[0];
   assign table_full = count_ff >= COUNT_W'(TABLE_CAPACITY);
   assign do_insert  = !hit && !table_full;
   assign folded     = fold_case(req_text_byte);

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hash_ff       <= FNV_BASIS;
         seen_ff       <= 1'b0;
         gap_ff        <= 1'b0;
         stopped_ff    <= 1'b0;
         last_ff       <= 1'b0;
         wait_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hash_ff       <= hash_in;
         seen_ff       <= seen_in;
         gap_ff        <= gap_in;
         stopped_ff    <= stopped_in;
         last_ff       <= last_in;
         wait_ff       <= wait_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_ins_ff   <= rsp_ins_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_total_ff <= rsp_total_in;
      rsp_hash_ff  <= rsp_hash_in;
   end

   always_comb begin
      state_in      = state_ff;
      hash_in       = hash_ff;
      seen_in       = seen_ff;
      gap_in        = gap_ff;
      stopped_in    = stopped_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      wait_in       = wait_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_dup_in    = rsp_dup_ff;
      rsp_ins_in    = rsp_ins_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_hash_in   = rsp_hash_ff;
      cell_ctrl     = '0;
      count_wide    = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               last_in  = req_last_byte;
               state_in = req_last_byte ? S_CMP : S_IDLE;
               if (!stopped_ff) begin
                  if (req_text_byte == NUL_CHAR) begin
                     stopped_in = 1'b1;
                  end else if (req_text_byte <= SPACE_CHAR) begin
                     // Whitespace only counts once something visible is in.
                     if (seen_ff) begin
                        gap_in = 1'b1;
                     end
                  end else if (gap_ff) begin
                     // Mix the collapsed space now, the byte itself next cycle.
                     hash_in  = fnv_mix(hash_ff, SPACE_CHAR);
                     gap_in   = 1'b0;
                     seen_in  = 1'b1;
                     byte_in  = folded;
                     state_in = S_MIX;
                  end else begin
                     hash_in = fnv_mix(hash_ff, folded);
                     seen_in = 1'b1;
                  end
               end
            end
         end

         S_MIX: begin
            hash_in  = fnv_mix(hash_ff, byte_ff);
            state_in = last_ff ? S_CMP : S_IDLE;
         end

         S_CMP: begin
            cell_ctrl.cmp_en = 1'b1;
            wait_in          = '0;
            state_in         = S_WAIT;
         end

         S_WAIT: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_LAST) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            cell_ctrl.shift_en = do_insert;
            count_in           = count_ff + COUNT_W'(do_insert);
            count_wide         = 32'(count_in);
            rsp_strobe_in      = 1'b1;
            rsp_dup_in         = hit;
            rsp_ins_in         = do_insert;
            rsp_full_in        = !hit && table_full;
            rsp_total_in       = count_wide[TOTAL_W-1:0];
            rsp_hash_in        = hash_ff;
            // The next message starts from a clean slate.
            hash_in            = FNV_BASIS;
            seen_in            = 1'b0;
            gap_in             = 1'b0;
            stopped_in         = 1'b0;
            state_in           = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_is_duplicate = rsp_dup_ff;
   assign rsp_was_inserted = rsp_ins_ff;
   assign rsp_set_full     = rsp_full_ff;
   assign rsp_entry_total  = rsp_total_ff;
   assign rsp_message_hash = rsp_hash_ff;

   assign rsp_flags = {rsp_dup_ff, rsp_ins_ff, rsp_full_ff};

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `NHDS_ASSERT_NXT(a_decide_gives_rsp, clock, reset, state_ff == S_DECIDE, rsp_strobe_ff)
   `NHDS_ASSERT_IMP(a_rsp_one_outcome, clock, reset, rsp_strobe_ff, $onehot(rsp_flags))
   `NHDS_ASSERT_IMP(a_count_bounded, clock, reset, 1'b1, count_ff <= COUNT_W'(TABLE_CAPACITY))
   `NHDS_ASSERT_IMP(a_single_match, clock, reset, state_ff == S_WAIT, $onehot0(cell_eq))
   `NHDS_ASSERT_NXT(a_insert_counts, clock, reset, state_ff == S_DECIDE && do_insert, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire
